// File: design/rsb_pkg.sv
// Shared types and constants for the retransmit scoreboard.
`default_nettype none
package rsb_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int HANDLE_BITS = 16;

  localparam int CMD_BITS    = 3;
  localparam int SEQ_BITS    = 32;
  localparam int HDL_BITS    = 16;
  localparam int TIME_BITS   = 32;
  localparam int STATUS_BITS = 3;

  // Stored handles keep only the low HANDLE_BITS bits of the port field.
  localparam int HANDLE_KEEP = (HANDLE_BITS < HDL_BITS) ? HANDLE_BITS : HDL_BITS;
  localparam logic [HDL_BITS-1:0] HANDLE_MASK = HDL_BITS'((64'd1 << HANDLE_KEEP) - 64'd1);

  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(1000);

  localparam logic [CMD_BITS-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_CACK  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_SACK  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_SCAN  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_FLUSH = 3'd4;

  localparam logic [STATUS_BITS-1:0] STS_FREED   = 3'd0;
  localparam logic [STATUS_BITS-1:0] STS_RESEND  = 3'd1;
  localparam logic [STATUS_BITS-1:0] STS_STALE   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STS_PENDING = 3'd3;
  localparam logic [STATUS_BITS-1:0] STS_NOTHING = 3'd4;
  localparam logic [STATUS_BITS-1:0] STS_LOADED  = 3'd5;
  localparam logic [STATUS_BITS-1:0] STS_FULL    = 3'd6;

  typedef struct packed {
    logic [SEQ_BITS-1:0]  seq;
    logic [HDL_BITS-1:0]  hdl;
    logic [TIME_BITS-1:0] sent;
  } entry_t;

endpackage
`default_nettype wire

// File: design/retransmit_scoreboard_core.sv
// Top level: table of packets in flight with load, ack, timeout scan and flush.
// Walking commands read the entry RAM one entry a cycle in S_SCAN, then pass through S_DONE;
// the last result strobes in the first idle cycle, and a new command is taken only when idle.
// Each hit is held until the next hit or the end of the walk; results never overlap.
// Stale selective acks and undefined codes go straight to S_DONE; result in the first idle cycle.
// Receiver cannot stall. Reset clears valid bits and last cumulative ack, timeout to 1000.
`default_nettype none
module retransmit_scoreboard_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rsb_pkg::CMD_BITS-1:0]    in_cmd,
  input  wire logic [rsb_pkg::SEQ_BITS-1:0]    in_seq_number,
  input  wire logic [rsb_pkg::HDL_BITS-1:0]    in_buffer_handle,
  input  wire logic [rsb_pkg::TIME_BITS-1:0]   in_time_now,
  output logic                                 out_strobe,
  output logic      [rsb_pkg::STATUS_BITS-1:0] out_status,
  output logic      [rsb_pkg::SEQ_BITS-1:0]    out_seq_out,
  output logic      [rsb_pkg::HDL_BITS-1:0]    out_handle_out,
  output logic      [rsb_pkg::TIME_BITS-1:0]   out_sent_at,
  output logic      [rsb_pkg::TIME_BITS-1:0]   out_round_trip,
  output logic                                 out_is_last,
  output logic                                 out_table_empty,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rsb_pkg::TIME_BITS-1:0]   cfg_timeout_ticks
);
  import rsb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  localparam logic [TABLE_DEPTH-1:0] ONE_HOT0 = TABLE_DEPTH'(1);

  state_t                  state_r;
  logic [TABLE_DEPTH-1:0]  valid_r;
  logic [SEQ_BITS-1:0]     last_cum_r;
  logic [TIME_BITS-1:0]    timeout_r;

  logic [CMD_BITS-1:0]     cmd_r;
  logic [SEQ_BITS-1:0]     seq_r;
  logic [HDL_BITS-1:0]     hdl_r;
  logic [TIME_BITS-1:0]    now_r;
  logic                    stale_r;

  logic [CNT_BITS-1:0]     cnt_r;
  logic                    chk_vld_r;
  logic [IDX_BITS-1:0]     chk_idx_r;
  logic                    found_r;
  logic [IDX_BITS-1:0]     found_idx_r;
  logic                    free_found_r;
  logic [IDX_BITS-1:0]     free_idx_r;

  logic                    pend_vld_r;
  logic [STATUS_BITS-1:0]  pend_status_r;
  logic [SEQ_BITS-1:0]     pend_seq_r;
  logic [HDL_BITS-1:0]     pend_hdl_r;
  logic [TIME_BITS-1:0]    pend_sent_r;
  logic [TIME_BITS-1:0]    pend_rtt_r;
  logic                    pend_empty_r;

  logic                    out_strobe_r;
  logic [STATUS_BITS-1:0]  out_status_r;
  logic [SEQ_BITS-1:0]     out_seq_r;
  logic [HDL_BITS-1:0]     out_hdl_r;
  logic [TIME_BITS-1:0]    out_sent_r;
  logic [TIME_BITS-1:0]    out_rtt_r;
  logic                    out_last_r;
  logic                    out_empty_r;

  entry_t                  rd_ent;
  entry_t                  wr_ent;
  logic                    wr_en;
  logic [IDX_BITS-1:0]     wr_addr;
  logic [IDX_BITS-1:0]     rd_addr;

  logic                    accept;
  logic                    ent_valid;
  logic                    seq_eq;
  logic                    seq_le;
  logic [TIME_BITS-1:0]    age;
  logic                    match_hit;
  logic                    rel_hit;
  logic [TABLE_DEPTH-1:0]  valid_after;
  logic [STATUS_BITS-1:0]  rel_status;
  logic [TIME_BITS-1:0]    rel_rtt;
  logic                    walk_end;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_addr   = cnt_r[IDX_BITS-1:0];
  assign walk_end  = (cnt_r == CNT_BITS'(TABLE_DEPTH));

  // Compare stage: RAM data belongs to chk_idx_r.
  always_comb begin
    ent_valid   = chk_vld_r && valid_r[chk_idx_r];
    seq_eq      = (rd_ent.seq == seq_r);
    seq_le      = (rd_ent.seq <= seq_r);
    age         = now_r - rd_ent.sent;
    match_hit   = 1'b0;
    rel_hit     = 1'b0;
    rel_status  = STS_FREED;
    rel_rtt     = '0;
    case (cmd_r)
      CMD_LOAD: begin
        match_hit = ent_valid && seq_eq && !found_r;
      end
      CMD_CACK: begin
        rel_hit = ent_valid && seq_le;
        rel_rtt = age;
      end
      CMD_SACK: begin
        rel_hit = ent_valid && seq_eq && !found_r;
        rel_rtt = age;
      end
      CMD_SCAN: begin
        rel_hit    = ent_valid && (age > timeout_r);
        rel_status = STS_RESEND;
      end
      CMD_FLUSH: begin
        rel_hit = ent_valid;
      end
      default: begin
        rel_hit = 1'b0;
      end
    endcase
    valid_after = valid_r & ~(ONE_HOT0 << chk_idx_r);
  end

  assign wr_en   = (state_r == S_DONE) && (cmd_r == CMD_LOAD) && (found_r || free_found_r);
  assign wr_addr = found_r ? found_idx_r : free_idx_r;
  assign wr_ent  = '{seq: seq_r, hdl: hdl_r, sent: now_r};

  rsb_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_addr(rd_addr),
    .rd_data(rd_ent)
  );

  always_ff @(posedge clk) begin
    out_strobe_r <= 1'b0;
    chk_vld_r    <= 1'b0;

    if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_timeout_ticks;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r        <= in_cmd;
          seq_r        <= in_seq_number;
          hdl_r        <= in_buffer_handle & HANDLE_MASK;
          now_r        <= in_time_now;
          cnt_r        <= '0;
          found_r      <= 1'b0;
          free_found_r <= 1'b0;
          pend_vld_r   <= 1'b0;
          stale_r      <= (in_cmd == CMD_SACK) && (in_seq_number <= last_cum_r);
          if (in_cmd == CMD_CACK) begin
            last_cum_r <= in_seq_number;
          end
          if ((in_cmd > CMD_FLUSH) ||
              ((in_cmd == CMD_SACK) && (in_seq_number <= last_cum_r))) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is being checked.
        if (!walk_end) begin
          cnt_r     <= cnt_r + CNT_BITS'(1);
          chk_vld_r <= 1'b1;
          chk_idx_r <= cnt_r[IDX_BITS-1:0];
        end else begin
          state_r <= S_DONE;
        end

        if (match_hit) begin
          found_r     <= 1'b1;
          found_idx_r <= chk_idx_r;
        end
        if (chk_vld_r && !valid_r[chk_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= chk_idx_r;
        end

        if (rel_hit) begin
          valid_r <= valid_after;
          if (cmd_r == CMD_SACK) begin
            found_r <= 1'b1;
          end
          // Push out the held result; it is not the last one.
          if (pend_vld_r) begin
            out_strobe_r <= 1'b1;
            out_status_r <= pend_status_r;
            out_seq_r    <= pend_seq_r;
            out_hdl_r    <= pend_hdl_r;
            out_sent_r   <= pend_sent_r;
            out_rtt_r    <= pend_rtt_r;
            out_last_r   <= 1'b0;
            out_empty_r  <= pend_empty_r;
          end
          pend_vld_r    <= 1'b1;
          pend_status_r <= rel_status;
          pend_seq_r    <= rd_ent.seq;
          pend_hdl_r    <= rd_ent.hdl;
          pend_sent_r   <= rd_ent.sent;
          pend_rtt_r    <= rel_rtt;
          pend_empty_r  <= (valid_after == '0);
        end
      end

      S_DONE: begin
        state_r      <= S_IDLE;
        out_strobe_r <= 1'b1;
        out_last_r   <= 1'b1;
        out_seq_r    <= seq_r;
        out_hdl_r    <= '0;
        out_sent_r   <= '0;
        out_rtt_r    <= '0;
        out_empty_r  <= (valid_r == '0);
        if (pend_vld_r) begin
          out_status_r <= pend_status_r;
          out_seq_r    <= pend_seq_r;
          out_hdl_r    <= pend_hdl_r;
          out_sent_r   <= pend_sent_r;
          out_rtt_r    <= pend_rtt_r;
          out_empty_r  <= pend_empty_r;
        end else if (cmd_r == CMD_LOAD) begin
          out_hdl_r   <= hdl_r;
          out_sent_r  <= now_r;
          out_empty_r <= 1'b0;
          if (found_r || free_found_r) begin
            out_status_r <= STS_LOADED;
            valid_r      <= valid_r | (ONE_HOT0 << wr_addr);
          end else begin
            out_status_r <= STS_FULL;
          end
        end else if (stale_r) begin
          out_status_r <= STS_STALE;
        end else if (cmd_r == CMD_SACK) begin
          out_status_r <= STS_PENDING;
        end else begin
          out_status_r <= STS_NOTHING;
        end
      end

      default: begin
        state_r <= S_IDLE;
      end
    endcase

    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      last_cum_r   <= '0;
      timeout_r    <= TIMEOUT_RESET;
      out_strobe_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      pend_vld_r   <= 1'b0;
      cnt_r        <= '0;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_seq_out     = out_seq_r;
  assign out_handle_out  = out_hdl_r;
  assign out_sent_at     = out_sent_r;
  assign out_round_trip  = out_rtt_r;
  assign out_is_last     = out_last_r;
  assign out_table_empty = out_empty_r;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_last) |-> !busy)
    else $error("final result strobed while still busy");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_is_last) |-> busy)
    else $error("non-final result with block idle");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_addr)])
    else $error("written entry not marked valid");

  a_loaded_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == STS_LOADED)) |-> !out_table_empty)
    else $error("table reported empty after a load");
`endif

endmodule
`default_nettype wire

// File: design/rsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: verif/retransmit_scoreboard_core_tb.sv
// Self-checking testbench for the retransmit scoreboard core.
`default_nettype none
module retransmit_scoreboard_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsb_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 42;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SEQ_BITS-1:0]    seq;
    logic [HDL_BITS-1:0]    hdl;
    logic [TIME_BITS-1:0]   sent;
    logic [TIME_BITS-1:0]   rtt;
    logic                   last;
    logic                   empty;
  } outcome_t;

  // Mirror of the flight table plus the queue of outcomes still owed by the block.
  class flight_table;
    logic [TIME_BITS-1:0] timeout;
    bit                   live    [TABLE_DEPTH];
    logic [SEQ_BITS-1:0]  seq_of  [TABLE_DEPTH];
    logic [HDL_BITS-1:0]  hdl_of  [TABLE_DEPTH];
    logic [TIME_BITS-1:0] sent_of [TABLE_DEPTH];
    logic [SEQ_BITS-1:0]  last_cum;
    outcome_t             awaited[$];
    int mismatches;
    int checked;
    int full_seen;
    int freed_seen;
    int resent_seen;

    function new();
      timeout = TIMEOUT_RESET;
      last_cum = '0;
      foreach (live[i]) live[i] = 1'b0;
      mismatches = 0;
      checked = 0;
      full_seen = 0;
      freed_seen = 0;
      resent_seen = 0;
    endfunction

    function bit table_clear();
      foreach (live[i]) if (live[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void post(logic [STATUS_BITS-1:0] status, logic [SEQ_BITS-1:0] seq,
                       logic [HDL_BITS-1:0] hdl, logic [TIME_BITS-1:0] sent,
                       logic [TIME_BITS-1:0] rtt);
      outcome_t o;
      o.status = status;
      o.seq = seq;
      o.hdl = hdl;
      o.sent = sent;
      o.rtt = rtt;
      o.last = 1'b0;
      o.empty = table_clear();
      awaited = {awaited, o};
    endfunction

    function void drop_entry(int i, logic [STATUS_BITS-1:0] status, logic [TIME_BITS-1:0] rtt);
      live[i] = 1'b0;
      if (status == STS_RESEND) resent_seen++;
      else freed_seen++;
      post(status, seq_of[i], hdl_of[i], sent_of[i], rtt);
    endfunction

    function void note_command(logic [CMD_BITS-1:0] cmd, logic [SEQ_BITS-1:0] seq,
                               logic [HDL_BITS-1:0] hdl, logic [TIME_BITS-1:0] now);
      int first;
      int slot;
      logic [HDL_BITS-1:0] h;
      logic [TIME_BITS-1:0] age;
      first = awaited.size();
      h = hdl & HANDLE_MASK;
      case (cmd)
        CMD_LOAD: begin
          slot = -1;
          for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
            if (live[i] && seq_of[i] == seq) slot = i;
          for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
            if (!live[i]) slot = i;
          if (slot < 0) begin
            full_seen++;
            post(STS_FULL, seq, h, now, '0);
          end else begin
            live[slot] = 1'b1;
            seq_of[slot] = seq;
            hdl_of[slot] = h;
            sent_of[slot] = now;
            post(STS_LOADED, seq, h, now, '0);
          end
        end
        CMD_CACK: begin
          last_cum = seq;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (live[i] && seq_of[i] <= seq) drop_entry(i, STS_FREED, now - sent_of[i]);
        end
        CMD_SACK: begin
          if (seq <= last_cum) begin
            post(STS_STALE, seq, '0, '0, '0);
          end else begin
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
              if (live[i] && seq_of[i] == seq) slot = i;
            if (slot >= 0) drop_entry(slot, STS_FREED, now - sent_of[slot]);
            else post(STS_PENDING, seq, '0, '0, '0);
          end
        end
        CMD_SCAN: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            age = now - sent_of[i];
            if (live[i] && age > timeout) drop_entry(i, STS_RESEND, '0);
          end
        end
        CMD_FLUSH: begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (live[i]) drop_entry(i, STS_FREED, '0);
        end
        default: ;
      endcase
      if (awaited.size() == first) post(STS_NOTHING, seq, '0, '0, '0);
      // flag the final outcome of this command
      awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string line);
      $display("mismatch @%0t: %s", $time, line);
      mismatches++;
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d seq %h",
                                  got.status, got.seq));
        return;
      end
      want = awaited.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("status got %0d want %0d (seq %h)",
                                  got.status, want.status, want.seq));
      if (got.seq != want.seq)
        report_mismatch($sformatf("seq_out got %h want %h", got.seq, want.seq));
      if (got.hdl != want.hdl)
        report_mismatch($sformatf("handle_out got %h want %h (seq %h)",
                                  got.hdl, want.hdl, want.seq));
      if (got.sent != want.sent)
        report_mismatch($sformatf("sent_at got %h want %h (seq %h)",
                                  got.sent, want.sent, want.seq));
      if (got.rtt != want.rtt)
        report_mismatch($sformatf("round_trip got %h want %h (seq %h)",
                                  got.rtt, want.rtt, want.seq));
      if (got.last != want.last)
        report_mismatch($sformatf("is_last got %0d want %0d (seq %h)",
                                  got.last, want.last, want.seq));
      if (got.empty != want.empty)
        report_mismatch($sformatf("table_empty got %0d want %0d (seq %h)",
                                  got.empty, want.empty, want.seq));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_BITS-1:0]    in_cmd = '0;
  logic [SEQ_BITS-1:0]    in_seq_number = '0;
  logic [HDL_BITS-1:0]    in_buffer_handle = '0;
  logic [TIME_BITS-1:0]   in_time_now = '0;
  logic                   out_strobe;
  logic [STATUS_BITS-1:0] out_status;
  logic [SEQ_BITS-1:0]    out_seq_out;
  logic [HDL_BITS-1:0]    out_handle_out;
  logic [TIME_BITS-1:0]   out_sent_at;
  logic [TIME_BITS-1:0]   out_round_trip;
  logic                   out_is_last;
  logic                   out_table_empty;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [TIME_BITS-1:0]   cfg_timeout_ticks = '0;

  flight_table sb = new();

  int items_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [SEQ_BITS-1:0]  seq_cursor = 32'd1000;
  logic [TIME_BITS-1:0] tick_cursor = 32'hFFFF_F000;

  retransmit_scoreboard_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_seq_number     (in_seq_number),
    .in_buffer_handle  (in_buffer_handle),
    .in_time_now       (in_time_now),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_seq_out       (out_seq_out),
    .out_handle_out    (out_handle_out),
    .out_sent_at       (out_sent_at),
    .out_round_trip    (out_round_trip),
    .out_is_last       (out_is_last),
    .out_table_empty   (out_table_empty),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_timeout_ticks (cfg_timeout_ticks)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    outcome_t got;
    if (rst_n && out_strobe) begin
      got.status = out_status;
      got.seq = out_seq_out;
      got.hdl = out_handle_out;
      got.sent = out_sent_at;
      got.rtt = out_round_trip;
      got.last = out_is_last;
      got.empty = out_table_empty;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the word on the ports until the block takes it; start stays high.
  task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [SEQ_BITS-1:0] seq,
                       input logic [HDL_BITS-1:0] hdl, input logic [TIME_BITS-1:0] now);
    start <= 1'b1;
    in_cmd <= cmd;
    in_seq_number <= seq;
    in_buffer_handle <= hdl;
    in_time_now <= now;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, seq, hdl, now);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TIME_BITS-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_timeout_ticks <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.timeout = val;
    cfg_writes++;
  endtask

  // Bursts of back-to-back words with random gaps; now and then drain completely.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 29) == 0) begin
        wait_idle();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
  endtask

  function automatic logic [TIME_BITS-1:0] next_tick(input int spread);
    tick_cursor = tick_cursor + $urandom_range(0, spread);
    return tick_cursor;
  endfunction

  function automatic int pick_live();
    int hits[$];
    for (int i = 0; i < TABLE_DEPTH; i++) if (sb.live[i]) hits = {hits, i};
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  task automatic run_phase(input int count);
    int done;
    int kind;
    int len;
    int idx;
    logic [SEQ_BITS-1:0] s;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // run of loads, sometimes long enough to fill the table
        len = ($urandom_range(0, 5) == 0) ? TABLE_DEPTH + 4 : $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          idx = pick_live();
          if (idx >= 0 && $urandom_range(0, 4) == 0) begin
            s = sb.seq_of[idx];
          end else begin
            seq_cursor = seq_cursor + $urandom_range(1, 3);
            s = seq_cursor;
          end
          pace();
          issue(CMD_LOAD, s, HDL_BITS'($urandom), next_tick(40));
          done++;
        end
      end else begin
        pace();
        idx = pick_live();
        if (kind < 55) begin
          if (idx >= 0 && $urandom_range(0, 9) < 7) s = sb.seq_of[idx];
          else s = sb.last_cum + $urandom_range(0, 6) - 3;
          issue(CMD_SACK, s, HDL_BITS'($urandom), next_tick(40));
        end else if (kind < 67) begin
          if ($urandom_range(0, 7) == 0)
            s = (sb.last_cum > 20) ? sb.last_cum - $urandom_range(1, 20) : '0;
          else if (idx >= 0) s = sb.seq_of[idx];
          else s = seq_cursor - $urandom_range(0, 3);
          issue(CMD_CACK, s, HDL_BITS'($urandom), next_tick(40));
        end else if (kind < 82) begin
          issue(CMD_SCAN, $urandom, HDL_BITS'($urandom), next_tick(1500));
        end else if (kind < 88) begin
          issue(CMD_FLUSH, $urandom, HDL_BITS'($urandom), next_tick(40));
        end else if (kind < 95) begin
          issue(CMD_BITS'($urandom_range(CMD_LOAD, CMD_FLUSH)), $urandom,
                HDL_BITS'($urandom), $urandom);
        end else begin
          // undefined codes change nothing in the table and do not count
          issue(CMD_BITS'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), $urandom,
                HDL_BITS'($urandom), $urandom);
          done--;
        end
        done++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing to free, stale and pending acks, undefined codes
    issue(CMD_CACK, 32'd0, 16'h0000, 32'hFFFF_FFF0);
    issue(CMD_SACK, 32'd0, 16'hFFFF, 32'hFFFF_FFF0);
    issue(CMD_SACK, 32'd5, 16'h0000, 32'hFFFF_FFF1);
    issue(CMD_SCAN, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_FLUSH, 32'd0, 16'h0000, 32'd0);
    issue(CMD_UNUSED_FIRST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_UNUSED_FIRST + 3'd1, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA);
    issue(CMD_UNUSED_LAST, 32'd0, 16'h0000, 32'd0);
    // loads across the tick wrap, max sequence number, overwrite in place
    issue(CMD_LOAD, 32'd10, 16'hFFFF, 32'hFFFF_FFF0);
    issue(CMD_LOAD, 32'd20, 16'h0000, 32'd5);
    issue(CMD_LOAD, 32'hFFFF_FFFF, 16'h1234, 32'd100);
    issue(CMD_LOAD, 32'd10, 16'hA5A5, 32'd200);
    issue(CMD_SACK, 32'd20, 16'h0000, 32'd300);
    // age equal to the timeout is kept, one tick more is resent
    issue(CMD_SCAN, 32'd0, 16'h0000, 32'd1100);
    issue(CMD_SCAN, 32'd0, 16'h0000, 32'd1101);
    issue(CMD_CACK, 32'd15, 16'h0000, 32'd1200);
    issue(CMD_SACK, 32'd12, 16'h0000, 32'd1201);
    issue(CMD_SACK, 32'd15, 16'h0000, 32'd1202);
    // cumulative ack moving backward
    issue(CMD_CACK, 32'd3, 16'h0000, 32'd1203);
    issue(CMD_LOAD, 32'd0, 16'h0F0F, 32'd1204);
    issue(CMD_SACK, 32'd0, 16'h0000, 32'd1205);
    issue(CMD_LOAD, 32'd4, 16'hF0F0, 32'd1206);
    issue(CMD_SACK, 32'd4, 16'h0000, 32'd1300);
    issue(CMD_LOAD, 32'd7, 16'h8001, 32'd1301);
    issue(CMD_FLUSH, 32'd9, 16'h0000, 32'd1302);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_timeout('0);
        1: set_timeout('1);
        2: set_timeout($urandom_range(20, 300));
        3: set_timeout($urandom_range(300, 1500));
        4: set_timeout($urandom);
        default: set_timeout(TIMEOUT_RESET);
      endcase
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("summary: %0d commands, %0d results checked, %0d timeout settings",
             items_sent, sb.checked, cfg_writes);
    $display("summary: %0d freed, %0d resent, %0d loads into a full table",
             sb.freed_seen, sb.resent_seen, sb.full_seen);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
design/rsb_pkg.sv
design/rsb_ram.sv
design/retransmit_scoreboard_core.sv
verif/retransmit_scoreboard_core_tb.sv
